>>> rtl/tqg_pkg.sv
// shared types, constants and tracker function for the touch quadrant gesture block
package tqg_pkg;

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // reset values of the centre registers and of the anchor
  localparam logic [7:0]  CENTER_X_RESET = 8'd120;
  localparam logic [11:0] CENTER_Y_RESET = 12'd160;

  // dual mode codes
  localparam logic [1:0] DM_SINGLE = 2'd0;
  localparam logic [1:0] DM_ARMED  = 2'd1;
  localparam logic [1:0] DM_DUAL   = 2'd2;

  // tracker states with a meaning of their own
  localparam logic [2:0] TRK_IDLE  = 3'd0;
  localparam logic [2:0] TRK_ENTRY = 3'd1;
  localparam logic [2:0] TRK_LAST  = 3'd4;
  localparam logic [2:0] TRK_DONE  = 3'd5;

  // configuration register indexes
  localparam logic [1:0] REG_GESTURE_ENABLE = 2'd0;
  localparam logic [1:0] REG_CENTER_X       = 2'd1;
  localparam logic [1:0] REG_CENTER_Y       = 2'd2;

  typedef enum logic [1:0] {
    QUAD_TR,
    QUAD_TL,
    QUAD_BL,
    QUAD_BR
  } quad_t;

  typedef enum logic {
    PH_TAKE,
    PH_SECOND
  } phase_t;

  typedef struct packed {
    logic        gesture_enable;
    logic [7:0]  center_x;
    logic [11:0] center_y;
  } cfg_t;

  // one decoded and classified report
  typedef struct packed {
    logic [7:0]  x;
    logic [11:0] y;
    logic        finger;
    quad_t       quad;
    logic        entry;
  } item_t;

  typedef struct packed {
    logic       second_pending;
    logic [1:0] dual_mode;
  } status_t;

  typedef struct packed {
    logic [2:0] state;
    logic       closed;
  } trk_t;

  // quadrant expected at position idx of loop a (counterclockwise) or loop b (clockwise)
  function automatic quad_t loop_quad(input logic loop_b, input logic [2:0] idx);
    quad_t q;
    unique case (idx)
      3'd0:    q = QUAD_TR;
      3'd1:    q = loop_b ? QUAD_BR : QUAD_TL;
      3'd2:    q = QUAD_BL;
      3'd3:    q = loop_b ? QUAD_TL : QUAD_BR;
      default: q = QUAD_TR;
    endcase
    return q;
  endfunction

  // one step of a loop tracker
  function automatic trk_t track_step(input logic [2:0] st, input logic loop_b,
                                      input quad_t quad, input logic entry);
    trk_t r;
    r.state  = st;
    r.closed = 1'b0;
    if (st == TRK_IDLE) begin
      r.state = entry ? TRK_ENTRY : TRK_IDLE;
    end else if (st <= TRK_LAST) begin
      if (quad == loop_quad(loop_b, st - 3'd1)) begin
        r.state = st;
      end else if (quad == loop_quad(loop_b, st)) begin
        r.state  = st + 3'd1;
        r.closed = (st == TRK_LAST);
      end else begin
        r.state = TRK_IDLE;
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/tqg_front.sv
// front part: decodes a report and classifies its quadrant
module tqg_front (
  input  tqg_pkg::cfg_t  cfg,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [23:0]    s_tdata,     // byte_x, byte_flags_yhigh, byte_ylow
  output logic           push_valid,
  input  logic           push_ready,
  output tqg_pkg::item_t push_item
);
  import tqg_pkg::*;

  logic [7:0]  x;
  logic [11:0] y;
  logic        top;
  logic        right;

  // unpack the report bytes
  assign x = s_tdata[7:0];
  assign y = {s_tdata[11:8], s_tdata[23:16]};

  // quadrant around the centre
  assign top   = y < cfg.center_y;
  assign right = x >= cfg.center_x;

  always_comb begin
    push_item.x      = x;
    push_item.y      = y;
    push_item.finger = s_tdata[15];
    push_item.entry  = (x > cfg.center_x) && top;
    if (top) begin
      push_item.quad = right ? QUAD_TR : QUAD_TL;
    end else begin
      push_item.quad = right ? QUAD_BR : QUAD_BL;
    end
  end

  // beat goes straight into the queue
  assign push_valid = s_tvalid;
  assign s_tready   = push_ready;

endmodule

>>> rtl/tqg_queue.sv
// short queue of classified reports between front and back
module tqg_queue #(
  parameter int Depth = tqg_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  tqg_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output tqg_pkg::item_t pop_item
);
  import tqg_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  item_t           entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;
  logic            pop;

  assign push_ready = count != CntW'(Depth);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/tqg_back.sv
// back part: loop trackers, dual mode and point output register
module tqg_back (
  input  logic             clk,
  input  logic             rst,
  input  tqg_pkg::cfg_t    cfg,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  tqg_pkg::item_t   pop_item,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_x,
  output logic [11:0]      out_y,
  output logic             out_touch,
  output logic             out_last,
  output tqg_pkg::status_t status
);
  import tqg_pkg::*;

  phase_t      phase;
  phase_t      phase_next;
  logic [2:0]  loop_a_state;
  logic [2:0]  loop_b_state;
  logic [1:0]  dual_mode;
  logic [7:0]  anchor_x;
  logic [11:0] anchor_y;
  logic [7:0]  live_x;
  logic [11:0] live_y;

  logic        out_free;
  logic        pop;
  logic        load_second;
  logic        run;
  trk_t        trk_a;
  trk_t        trk_b;
  logic [2:0]  a_mid;
  logic [2:0]  b_mid;
  logic [1:0]  dm_mid;
  logic [7:0]  anc_x_mid;
  logic [11:0] anc_y_mid;
  logic        two_points;
  logic [2:0]  loop_a_next;
  logic [2:0]  loop_b_next;
  logic [1:0]  dual_mode_next;
  logic [7:0]  anchor_x_next;
  logic [11:0] anchor_y_next;

  assign out_free = !out_valid || out_ready;

  // phase: next state
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_TAKE: begin
        if (pop && two_points) begin
          phase_next = PH_SECOND;
        end
      end
      PH_SECOND: begin
        if (out_free) begin
          phase_next = PH_TAKE;
        end
      end
      default: phase_next = PH_TAKE;
    endcase
  end

  // phase: outputs
  always_comb begin
    pop         = 1'b0;
    load_second = 1'b0;
    unique case (phase)
      PH_TAKE:   pop = pop_valid && out_free;
      PH_SECOND: load_second = out_free;
      default: begin
        pop         = 1'b0;
        load_second = 1'b0;
      end
    endcase
  end

  assign pop_ready = pop;

  // tracker step, then lift handling
  always_comb begin
    run   = (dual_mode < DM_DUAL) && pop_item.finger && cfg.gesture_enable;
    trk_a = track_step(loop_a_state, 1'b0, pop_item.quad, pop_item.entry);
    trk_b = track_step(loop_b_state, 1'b1, pop_item.quad, pop_item.entry);

    a_mid     = loop_a_state;
    b_mid     = loop_b_state;
    dm_mid    = dual_mode;
    anc_x_mid = anchor_x;
    anc_y_mid = anchor_y;
    if (run) begin
      a_mid = trk_a.state;
      b_mid = trk_b.state;
      if (trk_a.closed) begin
        dm_mid    = DM_DUAL;
        anc_x_mid = cfg.center_x;
        anc_y_mid = cfg.center_y;
      end
      if (trk_b.closed) begin
        dm_mid = DM_ARMED;
      end
    end

    two_points = dm_mid >= DM_DUAL;

    loop_a_next    = a_mid;
    loop_b_next    = b_mid;
    dual_mode_next = dm_mid;
    anchor_x_next  = anc_x_mid;
    anchor_y_next  = anc_y_mid;
    if (!pop_item.finger) begin
      if (b_mid == TRK_DONE) begin
        anchor_x_next  = pop_item.x;
        anchor_y_next  = pop_item.y;
        loop_b_next    = TRK_IDLE;
        dual_mode_next = DM_DUAL;
      end else begin
        dual_mode_next = DM_SINGLE;
        loop_a_next    = TRK_IDLE;
        loop_b_next    = TRK_IDLE;
      end
    end
  end

  // gesture state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_TAKE;
      loop_a_state <= TRK_IDLE;
      loop_b_state <= TRK_IDLE;
      dual_mode    <= DM_SINGLE;
      anchor_x     <= CENTER_X_RESET;
      anchor_y     <= CENTER_Y_RESET;
    end else begin
      phase <= phase_next;
      if (pop) begin
        loop_a_state <= loop_a_next;
        loop_b_state <= loop_b_next;
        dual_mode    <= dual_mode_next;
        anchor_x     <= anchor_x_next;
        anchor_y     <= anchor_y_next;
      end
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= pop || load_second;
    end
  end

  // output register payload and held live point
  always_ff @(posedge clk) begin
    if (pop) begin
      out_touch <= pop_item.finger;
      live_x    <= pop_item.x;
      live_y    <= pop_item.y;
      if (two_points) begin
        out_x    <= anc_x_mid;
        out_y    <= anc_y_mid;
        out_last <= 1'b0;
      end else begin
        out_x    <= pop_item.x;
        out_y    <= pop_item.y;
        out_last <= 1'b1;
      end
    end else if (load_second) begin
      out_x    <= live_x;
      out_y    <= live_y;
      out_last <= 1'b1;
    end
  end

  assign status.second_pending = (phase == PH_SECOND);
  assign status.dual_mode      = dual_mode;

endmodule

>>> rtl/touch_quadrant_gesture_dual_point_top.sv
// Touch report decoder with quadrant-loop gestures that fake a second touch point.
//
// Channels: the slave stream takes one 3-byte touch report per beat; the master
// stream gives one point per beat, with tlast on the final point of a report.
// A report yields one point, or in dual mode the anchor point and then the live
// point. The configuration port writes gesture_enable, center_x and center_y; the
// user must write them only while the block is idle; the block does not enforce it.
// The beat of a report is written into the queue at the edge that takes it; the
// back part moves its first point from the queue into the output register once
// the output register is free.
// Throughput: one report per cycle in single point mode while the receiver takes
// every point; in dual mode the back part takes no new report until the live
// point is loaded, since the single output register holds one point at a time.
// Reset clears the trackers, selects single point mode, puts the anchor and
// centre at (120, 160) and empties the queue and output register.
// When the receiver stalls, the output register holds its point, the back part
// stops and the queue fills; s_tready drops once the queue is full.
module touch_quadrant_gesture_dual_point_top #(
  parameter int QueueDepth = tqg_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_wr_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,      // byte_x [7:0], byte_flags_yhigh [15:8], byte_ylow [23:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,      // pos_x [7:0], pos_y [19:8], touching [20], zero [23:21]
  output logic        m_tlast
);
  import tqg_pkg::*;

  cfg_t        cfg;
  item_t       push_item;
  item_t       pop_item;
  logic        push_valid;
  logic        push_ready;
  logic        pop_valid;
  logic        pop_ready;
  logic [7:0]  pos_x;
  logic [11:0] pos_y;
  logic        touching;
  status_t     status;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gesture_enable <= 1'b0;
      cfg.center_x       <= CENTER_X_RESET;
      cfg.center_y       <= CENTER_Y_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_GESTURE_ENABLE: cfg.gesture_enable <= cfg_wr_data[0];
        REG_CENTER_X:       cfg.center_x       <= cfg_wr_data[7:0];
        REG_CENTER_Y:       cfg.center_y       <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  tqg_front u_front (
    .cfg        (cfg),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  tqg_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  tqg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_x     (pos_x),
    .out_y     (pos_y),
    .out_touch (touching),
    .out_last  (m_tlast),
    .status    (status)
  );

  assign m_tdata = {3'b000, touching, pos_y, pos_x};

  // a second point is pending exactly while the anchor point waits in the output
  assert property (@(posedge clk) disable iff (rst)
    status.second_pending == (m_tvalid && !m_tlast))
    else $error("second point pending out of step with output beat");

  // the unused dual mode code is never reached
  assert property (@(posedge clk) disable iff (rst)
    status.dual_mode <= DM_DUAL)
    else $error("dual mode took the unused code");

  // nothing is offered right after reset
  assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid && !status.second_pending)
    else $error("output beat present right after reset");

endmodule

>>> tb/tb_top.sv
// testbench for the touch quadrant gesture block: report stream in, point stream out
`timescale 1ns / 100ps

import tqg_pkg::*;

// one expected output point
typedef struct packed {
  logic [7:0]  x;
  logic [11:0] y;
  logic        touch;
  logic        last;
} touch_point_t;

// tracks gesture state and holds the points each accepted report should produce
class gesture_point_board;
  bit           enable;
  logic [7:0]   cen_x;
  logic [11:0]  cen_y;
  logic [2:0]   loop_a;
  logic [2:0]   loop_b;
  logic [1:0]   mode;
  logic [7:0]   anc_x;
  logic [11:0]  anc_y;
  touch_point_t pending_points[$];
  int           fails;
  int           checked;
  int           dual_reports;
  int           closes_a;
  int           closes_b;
  int           lift_anchors;

  function new();
    enable = 1'b0;
    cen_x  = CENTER_X_RESET;
    cen_y  = CENTER_Y_RESET;
    loop_a = TRK_IDLE;
    loop_b = TRK_IDLE;
    mode   = DM_SINGLE;
    anc_x  = CENTER_X_RESET;
    anc_y  = CENTER_Y_RESET;
  endfunction

  task report(string what);
    fails++;
    if (fails <= 40) $display("mismatch: %s", what);
  endtask

  function void set_config(bit en, logic [7:0] cx, logic [11:0] cy);
    enable = en;
    cen_x  = cx;
    cen_y  = cy;
  endfunction

  function int pending();
    return pending_points.size();
  endfunction

  // quadrant at position pos of the forward loop, or of the reverse loop
  function quad_t loop_point(bit rev, logic [2:0] pos);
    case (pos)
      3'd1: return rev ? QUAD_BR : QUAD_TL;
      3'd2: return QUAD_BL;
      3'd3: return rev ? QUAD_TL : QUAD_BR;
      default: return QUAD_TR;
    endcase
  endfunction

  function logic [2:0] next_loop_state(logic [2:0] st, bit rev, quad_t q, bit entry);
    if (st == TRK_IDLE) return entry ? TRK_ENTRY : TRK_IDLE;
    // closed and unused states hold until a lift
    if (st > TRK_LAST) return st;
    if (q == loop_point(rev, st - 3'd1)) return st;
    if (q == loop_point(rev, st)) return st + 3'd1;
    return TRK_IDLE;
  endfunction

  // advance the gesture state for one report and queue its points
  function void predict_report(logic [7:0] bx, logic [7:0] bf, logic [7:0] by);
    logic [11:0] y;
    bit          finger;
    bit          top;
    bit          right;
    bit          entry;
    quad_t       q;
    logic [2:0]  nxt;
    y      = {bf[3:0], by};
    finger = bf[7];

    // trackers run only with the finger down, detection on and no dual mode yet
    if (mode < DM_DUAL && finger && enable) begin
      top   = y < cen_y;
      right = bx >= cen_x;
      entry = (bx > cen_x) && top;
      q = top ? (right ? QUAD_TR : QUAD_TL) : (right ? QUAD_BR : QUAD_BL);
      nxt = next_loop_state(loop_a, 1'b0, q, entry);
      if (loop_a == TRK_LAST && nxt == TRK_DONE) begin
        mode  = DM_DUAL;
        anc_x = cen_x;
        anc_y = cen_y;
        closes_a++;
      end
      loop_a = nxt;
      nxt = next_loop_state(loop_b, 1'b1, q, entry);
      if (loop_b == TRK_LAST && nxt == TRK_DONE) begin
        mode = DM_ARMED;
        closes_b++;
      end
      loop_b = nxt;
    end

    // anchor point first in dual mode, live point always last
    if (mode < DM_DUAL) begin
      pending_points.push_back('{bx, y, finger, 1'b1});
    end else begin
      pending_points.push_back('{anc_x, anc_y, finger, 1'b0});
      pending_points.push_back('{bx, y, finger, 1'b1});
      dual_reports++;
    end

    // lift: an armed reverse loop takes the lift point as anchor, else clear
    if (!finger) begin
      if (loop_b == TRK_DONE) begin
        anc_x  = bx;
        anc_y  = y;
        loop_b = TRK_IDLE;
        mode   = DM_DUAL;
        lift_anchors++;
      end else begin
        mode   = DM_SINGLE;
        loop_a = TRK_IDLE;
        loop_b = TRK_IDLE;
      end
    end
  endfunction

  task check_point(logic [7:0] x, logic [11:0] y, logic touch, logic last, logic [2:0] pad);
    touch_point_t want;
    if (pending_points.size() == 0) begin
      report($sformatf("point x=%0d y=%0d with nothing expected", x, y));
      return;
    end
    want = pending_points.pop_front();
    checked++;
    if (x !== want.x)
      report($sformatf("pos_x %0d, expected %0d", x, want.x));
    if (y !== want.y)
      report($sformatf("pos_y %0d, expected %0d", y, want.y));
    if (touch !== want.touch)
      report($sformatf("touching %b, expected %b", touch, want.touch));
    if (last !== want.last)
      report($sformatf("tlast %b, expected %b", last, want.last));
    if (pad !== 3'b000)
      report($sformatf("tdata pad bits %b, expected zero", pad));
  endtask
endclass

module tb_top;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASES      = 8;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [11:0] cfg_wr_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;      // byte_x [7:0], byte_flags_yhigh [15:8], byte_ylow [23:16]
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;      // pos_x [7:0], pos_y [19:8], touching [20], zero [23:21]
  logic        m_tlast;

  gesture_point_board sb;
  int  sent;
  int  cycles = 0;
  bit  tx_gaps;
  bit  rx_stalls;

  // settings per random phase: extremes plus a few ordinary points
  bit          ph_en[PHASES] = '{1, 1, 1, 1, 0, 1, 1, 1};
  logic [7:0]  ph_cx[PHASES] = '{120, 0, 255, 128, 60, 0, 8, 200};
  logic [11:0] ph_cy[PHASES] = '{160, 0, 4095, 2048, 1000, 0, 4000, 40};

  touch_quadrant_gesture_dual_point_top dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // cycle count and hard stop
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // point monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_point(m_tdata[7:0], m_tdata[19:8], m_tdata[20], m_tlast, m_tdata[23:21]);
  end

  // receiver: runs of ready and stalls, mostly short stalls with a few long ones
  initial begin
    int hold;
    bit lvl;
    m_tready = 1'b0;
    hold = 0;
    lvl = 1'b0;
    forever begin
      @(negedge clk);
      if (hold == 0) begin
        if (!rx_stalls) begin
          lvl = 1'b1;
          hold = 1;
        end else begin
          lvl = !lvl;
          if (lvl) hold = $urandom_range(12, 1);
          else if ($urandom_range(9) == 0) hold = $urandom_range(60, 20);
          else hold = $urandom_range(3, 1);
        end
      end
      hold--;
      m_tready <= lvl;
    end
  end

  function automatic int pick_gap();
    int r;
    if (!tx_gaps) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // one report beat, with a random idle gap ahead of it
  task automatic send_report(logic [7:0] bx, logic [7:0] bf, logic [7:0] by);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {by, bf, bx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.predict_report(bx, bf, by);
    sent++;
  endtask

  task automatic send_xy(logic [7:0] x, logic [11:0] y, bit finger);
    send_report(x, {finger, 3'b000, y[11:8]}, y[7:0]);
  endtask

  // random point inside quadrant q; falls back to anything where q is empty
  task automatic send_in_quad(quad_t q, bit finger);
    logic [7:0]  x;
    logic [11:0] y;
    logic [7:0]  cx;
    logic [11:0] cy;
    cx = sb.cen_x;
    cy = sb.cen_y;
    if (q == QUAD_TR || q == QUAD_BR) begin
      // mostly strictly right so a top-right point can start a loop
      if (cx != 8'hFF && $urandom_range(7) != 0) x = 8'($urandom_range(255, cx + 1));
      else x = cx;
    end else begin
      if (cx == 8'd0) x = 8'($urandom);
      else x = 8'($urandom_range(cx - 1, 0));
    end
    if (q == QUAD_TR || q == QUAD_TL) begin
      if (cy == 12'd0) y = 12'($urandom);
      else y = 12'($urandom_range(cy - 1, 0));
    end else begin
      y = 12'($urandom_range(4095, cy));
    end
    send_report(x, {finger, 3'($urandom), y[11:8]}, y[7:0]);
  endtask

  // a loop with random dwell, the odd stray quadrant, extra moves and a lift
  task automatic send_gesture(bit rev);
    quad_t path[5];
    if (rev) path = '{QUAD_TR, QUAD_BR, QUAD_BL, QUAD_TL, QUAD_TR};
    else     path = '{QUAD_TR, QUAD_TL, QUAD_BL, QUAD_BR, QUAD_TR};
    for (int i = 0; i < 5; i++) begin
      repeat ($urandom_range(3, 1)) send_in_quad(path[i], 1'b1);
      if ($urandom_range(11) == 0) send_in_quad(quad_t'($urandom_range(3)), 1'b1);
    end
    repeat ($urandom_range(4, 0)) send_in_quad(quad_t'($urandom_range(3)), 1'b1);
    send_in_quad(quad_t'($urandom_range(3)), 1'b0);
  endtask

  task automatic write_config(bit en, logic [7:0] cx, logic [11:0] cy);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= REG_GESTURE_ENABLE;
    cfg_wr_data <= {11'd0, en};
    @(negedge clk);
    cfg_index   <= REG_CENTER_X;
    cfg_wr_data <= {4'd0, cx};
    @(negedge clk);
    cfg_index   <= REG_CENTER_Y;
    cfg_wr_data <= cy;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_config(en, cx, cy);
  endtask

  // hold the sender until every expected point has come out
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int goal;
    int r;
    int wait_cycles;
    sb          = new();
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_index   = REG_GESTURE_ENABLE;
    cfg_wr_data = 12'd0;
    s_tvalid    = 1'b0;
    s_tdata     = 24'd0;
    sent        = 0;
    tx_gaps     = 1'b1;
    rx_stalls   = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: field extremes with detection off at reset values
    send_report(8'h00, 8'h00, 8'h00);
    send_report(8'hFF, 8'hFF, 8'hFF);
    send_report(8'hFF, 8'h70, 8'hAA);
    drain();
    write_config(1'b1, 8'd120, 12'd160);
    // x on the centre line does not start a loop, a wrong quadrant resets one
    send_xy(8'd120, 12'd10, 1'b1);
    send_xy(8'd200, 12'd10, 1'b1);
    send_xy(8'd10, 12'd300, 1'b1);
    // forward loop closes: dual mode with the anchor at the centre, lift clears
    send_xy(8'd200, 12'd10, 1'b1);
    send_xy(8'd10, 12'd10, 1'b1);
    send_xy(8'd10, 12'd300, 1'b1);
    send_xy(8'd200, 12'd300, 1'b1);
    send_xy(8'd200, 12'd10, 1'b1);
    send_xy(8'd50, 12'd50, 1'b1);
    send_xy(8'd60, 12'd70, 1'b0);
    // reverse loop arms, lift sets the anchor, next lift clears
    send_xy(8'd255, 12'd0, 1'b1);
    send_xy(8'd255, 12'd4095, 1'b1);
    send_xy(8'd0, 12'd4095, 1'b1);
    send_xy(8'd0, 12'd0, 1'b1);
    send_xy(8'd121, 12'd159, 1'b1);
    send_xy(8'd33, 12'h123, 1'b0);
    send_xy(8'd77, 12'd88, 1'b1);
    send_xy(8'd77, 12'd88, 1'b0);
    drain();

    // random phases, one setting each
    for (int p = 0; p < PHASES; p++) begin
      drain();
      if (p == 5) write_config(1'b1, 8'($urandom), 12'($urandom));
      else write_config(ph_en[p], ph_cx[p], ph_cy[p]);
      tx_gaps   = (p != 3);
      rx_stalls = (p != 3) && (p != 6);
      goal = 25 + (p + 1) * 128;
      while (sent < goal) begin
        r = $urandom_range(9);
        if (r < 3) send_gesture(1'b0);
        else if (r < 6) send_gesture(1'b1);
        else if (r < 8) send_report(8'($urandom), 8'($urandom), 8'($urandom));
        else begin
          repeat ($urandom_range(6, 1)) send_in_quad(quad_t'($urandom_range(3)), 1'b1);
          send_in_quad(quad_t'($urandom_range(3)), 1'b0);
        end
      end
    end

    // wind down
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait_cycles = 0;
    while (sb.pending() != 0 && wait_cycles < 5000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (10) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d points never came out", sb.pending()));

    $display("covered %0d reports over %0d settings, %0d points checked, %0d dual reports",
             sent, PHASES + 2, sb.checked, sb.dual_reports);
    $display("forward loops closed %0d, reverse loops closed %0d, lift anchors %0d",
             sb.closes_a, sb.closes_b, sb.lift_anchors);
    if (sb.fails == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
